>>> sv/rtpt_pkg.sv
package rtpt_pkg;

   localparam int EdgeWidth  = 33;
   localparam int ProdWidth  = 66;
   localparam int CrossWidth = 67;
   localparam int DotWidth   = 102;
   // cross values split into a 33-bit unsigned low part and a 34-bit signed high part
   localparam int SplitWidth = 33;
   localparam int CfgIdxWidth = 3;

   localparam logic [CfgIdxWidth-1:0] CfgOriginX = 3'd0;
   localparam logic [CfgIdxWidth-1:0] CfgOriginY = 3'd1;
   localparam logic [CfgIdxWidth-1:0] CfgOriginZ = 3'd2;
   localparam logic [CfgIdxWidth-1:0] CfgDirX    = 3'd3;
   localparam logic [CfgIdxWidth-1:0] CfgDirY    = 3'd4;
   localparam logic [CfgIdxWidth-1:0] CfgDirZ    = 3'd5;
   localparam logic [CfgIdxWidth-1:0] CfgEps     = 3'd6;

   // at most one command per sequencer step
   typedef struct packed {
      logic load;
      logic xprod;
      logic dot_lo;
      logic dot_hi;
      logic decide;
   } cmd_type;

endpackage

>>> sv/ray_triangle_parity_test_unit.sv
// A request is taken in IDLE and passes the cross, dot-low, dot-high, wait and decide steps
// before the result is registered; the sequencer handles one triangle at a time and
// holds before its decide step while the previous result is still waiting.
// Cost is set by the cross-product stage and the two-pass dot product.
// Reset (synchronous, active high) restores ray registers to defaults
// (direction +y, epsilon 1) and clears hit count and parity.
module ray_triangle_parity_test_unit #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // v0_x,v0_y,v0_z,v1_x..v1_z,v2_x..v2_z
   input  logic         req_tlast,   // last_triangle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [((COUNT_WIDTH+2+7)/8)*8-1:0] rsp_tdata, // triangle_hit,hits_so_far,odd_parity
   output logic         rsp_tlast,   // query_done
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import rtpt_pkg::*;

   localparam int FracUnit = 1 << COORD_FRAC_BITS;
   localparam int RspWidth = ((COUNT_WIDTH + 2 + 7) / 8) * 8;

   logic signed [31:0] org_ff [3], dir_ff [3];
   logic [31:0]        eps_ff;
   cmd_type            cmd;
   logic               rsp_free;
   logic [COUNT_WIDTH+1:0] rdata;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) org_ff[k] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= 32'(FracUnit);
         dir_ff[2] <= '0;
         eps_ff <= 32'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CfgOriginX: org_ff[0] <= csr_data;
            CfgOriginY: org_ff[1] <= csr_data;
            CfgOriginZ: org_ff[2] <= csr_data;
            CfgDirX:    dir_ff[0] <= csr_data;
            CfgDirY:    dir_ff[1] <= csr_data;
            CfgDirZ:    dir_ff[2] <= csr_data;
            CfgEps:     eps_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rtpt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .rsp_free(rsp_free), .cmd(cmd)
   );

   rtpt_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .tri_in(req_tdata),
      .last_in(req_tlast), .org(org_ff), .dir(dir_ff), .eps(eps_ff),
      .rsp_tready(rsp_tready), .rsp_free(rsp_free), .rsp_tvalid(rsp_tvalid),
      .rsp_tdata(rdata), .rsp_tlast(rsp_tlast)
   );

   assign rsp_tdata = RspWidth'(rdata);
endmodule

>>> sv/rtpt_ctrl.sv
module rtpt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             rsp_free,
   output rtpt_pkg::cmd_type cmd
);
   import rtpt_pkg::*;

   typedef enum logic [5:0] {
      IDLE   = 6'b000001,
      CROSS  = 6'b000010,
      DOT_LO = 6'b000100,
      DOT_HI = 6'b001000,
      DECIDE = 6'b010000,
      WAIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = CROSS;
            end
         end
         CROSS: begin
            cmd.xprod = 1'b1;
            state_in = DOT_LO;
         end
         DOT_LO: begin
            cmd.dot_lo = 1'b1;
            state_in = DOT_HI;
         end
         DOT_HI: begin
            cmd.dot_hi = 1'b1;
            state_in = WAIT;
         end
         WAIT: begin
            if (rsp_free) state_in = DECIDE;
         end
         DECIDE: begin
            cmd.decide = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
   end

   a_decide_after_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> $past(state_ff == WAIT)) else $error("decide out of order");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("overlapping commands");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == CROSS) else $error("load did not start");
endmodule

>>> sv/rtpt_datapath.sv
module rtpt_datapath #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtpt_pkg::cmd_type      cmd,
   input  logic [287:0]           tri_in,
   input  logic                   last_in,
   input  logic signed [31:0]     org [3],
   input  logic signed [31:0]     dir [3],
   input  logic [31:0]            eps,
   input  logic                   rsp_tready,
   output logic                   rsp_free,
   output logic                   rsp_tvalid,
   output logic [COUNT_WIDTH+1:0] rsp_tdata,
   output logic                   rsp_tlast
);
   import rtpt_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   logic signed [EdgeWidth-1:0]  e1_ff [3], e2_ff [3], s_ff [3];
   logic signed [CrossWidth-1:0] h_ff [3], q_ff [3];
   logic signed [DotWidth-1:0]   a_ff, u_ff, v_ff, t_ff;
   logic                         last_ff;
   logic [COUNT_WIDTH-1:0]       tally_ff;
   logic                         par_ff;
   logic                         vld_ff;
   logic signed [EdgeWidth-1:0]  dx [3];
   logic signed [DotWidth-1:0]   a_part, u_part, v_part, t_part;

   // cross products of 33-bit vectors, exact
   function automatic logic signed [CrossWidth-1:0] xp(
      input logic signed [EdgeWidth-1:0] a1, input logic signed [EdgeWidth-1:0] a2,
      input logic signed [EdgeWidth-1:0] b1, input logic signed [EdgeWidth-1:0] b2);
      logic signed [ProdWidth-1:0] p1, p2;
      p1 = a1 * b2;
      p2 = a2 * b1;
      return CrossWidth'(p1) - CrossWidth'(p2);
   endfunction

   // dot product against one half of the cross vector; low half unsigned,
   // high half signed and weighted by 2^SplitWidth by the caller
   function automatic logic signed [DotWidth-1:0] dp_half(
      input logic signed [EdgeWidth-1:0] a [3], input logic signed [CrossWidth-1:0] b [3],
      input logic upper);
      logic signed [SplitWidth:0]           bs;
      logic signed [EdgeWidth+SplitWidth:0] p;
      logic signed [DotWidth-1:0]           r;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         bs = upper ? $signed(b[k][CrossWidth-1:SplitWidth])
                    : $signed({1'b0, b[k][SplitWidth-1:0]});
         p = a[k] * bs;
         r = r + DotWidth'(p);
      end
      return r;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) dx[k] = EdgeWidth'(dir[k]);
   end

   // one multiplier set, used for the low half and then the high half
   always_comb begin
      a_part = dp_half(e1_ff, h_ff, cmd.dot_hi);
      u_part = dp_half(s_ff, h_ff, cmd.dot_hi);
      v_part = dp_half(dx, q_ff, cmd.dot_hi);
      t_part = dp_half(e2_ff, q_ff, cmd.dot_hi);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EdgeWidth'($signed(tri_in[96+32*k +: 32]))
                        - EdgeWidth'($signed(tri_in[32*k +: 32]));
            e2_ff[k] <= EdgeWidth'($signed(tri_in[192+32*k +: 32]))
                        - EdgeWidth'($signed(tri_in[32*k +: 32]));
            s_ff[k]  <= EdgeWidth'(org[k]) - EdgeWidth'($signed(tri_in[32*k +: 32]));
         end
         last_ff <= last_in;
      end
      if (cmd.xprod) begin
         h_ff[0] <= xp(dx[1], dx[2], e2_ff[1], e2_ff[2]);
         h_ff[1] <= xp(dx[2], dx[0], e2_ff[2], e2_ff[0]);
         h_ff[2] <= xp(dx[0], dx[1], e2_ff[0], e2_ff[1]);
         q_ff[0] <= xp(s_ff[1], s_ff[2], e1_ff[1], e1_ff[2]);
         q_ff[1] <= xp(s_ff[2], s_ff[0], e1_ff[2], e1_ff[0]);
         q_ff[2] <= xp(s_ff[0], s_ff[1], e1_ff[0], e1_ff[1]);
      end
      if (cmd.dot_lo) begin
         a_ff <= a_part;
         u_ff <= u_part;
         v_ff <= v_part;
         t_ff <= t_part;
      end
      if (cmd.dot_hi) begin
         a_ff <= a_ff + (a_part <<< SplitWidth);
         u_ff <= u_ff + (u_part <<< SplitWidth);
         v_ff <= v_ff + (v_part <<< SplitWidth);
         t_ff <= t_ff + (t_part <<< SplitWidth);
      end
   end

   logic signed [DotWidth-1:0] aa, uu, vv, tt;
   logic                       hit;
   always_comb begin
      aa = a_ff[DotWidth-1] ? -a_ff : a_ff;
      uu = a_ff[DotWidth-1] ? -u_ff : u_ff;
      vv = a_ff[DotWidth-1] ? -v_ff : v_ff;
      tt = a_ff[DotWidth-1] ? -t_ff : t_ff;
      hit = (a_ff != '0) && (aa >= $signed({70'd0, eps})) && !uu[DotWidth-1]
            && (uu <= aa) && !vv[DotWidth-1] && (uu + vv <= aa)
            && !tt[DotWidth-1] && (tt != '0);
   end

   logic [COUNT_WIDTH-1:0] tally_nx;
   logic                   par_nx;
   assign tally_nx = (hit && tally_ff != CountMax) ? tally_ff + 1'b1 : tally_ff;
   assign par_nx   = par_ff ^ hit;
   assign rsp_free = !vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         tally_ff <= '0;
         par_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) vld_ff <= 1'b0;
         if (cmd.decide) begin
            vld_ff <= 1'b1;
            tally_ff <= last_ff ? '0 : tally_nx;
            par_ff <= last_ff ? 1'b0 : par_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_tdata <= {par_nx, tally_nx, hit};
         rsp_tlast <= last_ff;
      end
   end
   assign rsp_tvalid = vld_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!vld_ff || rsp_tready)) else $error("result overwritten");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && !last_ff && tally_ff == CountMax) |=> tally_ff == CountMax)
      else $error("tally wrapped");
endmodule
